// ----- hw/rtl/thick_line_side_offset_core_macros.svh -----
// Assertion macros for the thick line side offset core.
`ifndef THICK_LINE_SIDE_OFFSET_CORE_MACROS_SVH
`define THICK_LINE_SIDE_OFFSET_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TLSO_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tlso assertion failed");
`define TLSO_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tlso assertion failed");
`else
`define TLSO_ASSERT_IMPL(lbl, a, c)
`define TLSO_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ----- hw/rtl/tlso_pkg.sv -----
// Shared constants for the thick line side offset core.
package tlso_pkg;
  localparam int NORM_BITS = 30;
  localparam int W_BITS = 31;
  localparam int ROOT_BITS = 31;
  localparam int Q_BITS = 31;
  localparam int SQ_BITS = 2 * ROOT_BITS;
  localparam int DIV_N_BITS = 2 * Q_BITS;
  localparam int REG_THICKNESS = 0;
  localparam logic [W_BITS-1:0] WIDTH_RESET = 31'd2949;
endpackage

// ----- hw/rtl/tlso_front.sv -----
// Front stages: differences, magnitudes, normalization and squared length.
module tlso_front #(
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [4*COORD_BITS-1:0] in_crd,
  output logic out_valid,
  output logic [tlso_pkg::SQ_BITS-1:0] out_sum,
  // {ay, ax, degen, sdy, sdx, coords}
  output logic [4*COORD_BITS+3+2*tlso_pkg::NORM_BITS-1:0] out_sb
);
  localparam int CB = COORD_BITS;
  localparam int NB = tlso_pkg::NORM_BITS;
  localparam int PW = $clog2(CB + 1);
  localparam int XW = CB + 1 + NB;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [4*CB-1:0] crd1_r, crd2_r, crd3_r, crd4_r, crd5_r, crd6_r;
  logic signed [CB:0] dx1_r, dy1_r;
  logic [CB:0] ax2_r, ay2_r, ax3_r, ay3_r;
  logic [2:0] fl2_r, fl3_r, fl4_r, fl5_r, fl6_r;
  logic [PW-1:0] pos3_r;
  logic [NB-1:0] nax4_r, nay4_r, nax5_r, nay5_r, nax6_r, nay6_r;
  logic [2*NB-1:0] sqx5_r, sqy5_r;
  logic [tlso_pkg::SQ_BITS-1:0] sum6_r;

  logic signed [CB:0] dx_nxt, dy_nxt;
  logic [CB:0] ax_nxt, ay_nxt, m_or;
  logic [PW-1:0] pos_nxt, rsh, lsh;
  logic [XW-1:0] ex_x, ex_y;
  logic [NB-1:0] nax_nxt, nay_nxt;

  assign dx_nxt = $signed({in_crd[3*CB-1], in_crd[3*CB-1:2*CB]})
                - $signed({in_crd[CB-1], in_crd[CB-1:0]});
  assign dy_nxt = $signed({in_crd[4*CB-1], in_crd[4*CB-1:3*CB]})
                - $signed({in_crd[2*CB-1], in_crd[2*CB-1:CB]});
  assign ax_nxt = dx1_r[CB] ? (CB+1)'(0) - dx1_r : dx1_r;
  assign ay_nxt = dy1_r[CB] ? (CB+1)'(0) - dy1_r : dy1_r;
  assign m_or = ax2_r | ay2_r;

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i <= CB; i++) begin
      if (m_or[i]) pos_nxt = PW'(i);
    end
  end

  assign rsh = pos3_r - PW'(NB - 1);
  assign lsh = PW'(NB - 1) - pos3_r;

  always_comb begin
    ex_x = XW'(ax3_r);
    ex_y = XW'(ay3_r);
    if (pos3_r >= PW'(NB)) begin
      ex_x = ex_x >> rsh;
      ex_y = ex_y >> rsh;
    end else begin
      ex_x = ex_x << lsh;
      ex_y = ex_y << lsh;
    end
    nax_nxt = ex_x[NB-1:0];
    nay_nxt = ex_y[NB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd1_r <= in_crd;
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
      crd2_r <= crd1_r;
      ax2_r <= ax_nxt;
      ay2_r <= ay_nxt;
      fl2_r <= {(dx1_r == '0) && (dy1_r == '0), dy1_r[CB], dx1_r[CB]};
      crd3_r <= crd2_r;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      fl3_r <= fl2_r;
      pos3_r <= pos_nxt;
      crd4_r <= crd3_r;
      fl4_r <= fl3_r;
      nax4_r <= nax_nxt;
      nay4_r <= nay_nxt;
      crd5_r <= crd4_r;
      fl5_r <= fl4_r;
      nax5_r <= nax4_r;
      nay5_r <= nay4_r;
      sqx5_r <= nax4_r * nax4_r;
      sqy5_r <= nay4_r * nay4_r;
      crd6_r <= crd5_r;
      fl6_r <= fl5_r;
      nax6_r <= nax5_r;
      nay6_r <= nay5_r;
      sum6_r <= tlso_pkg::SQ_BITS'(sqx5_r) + tlso_pkg::SQ_BITS'(sqy5_r);
    end
  end

  assign out_valid = v6_r;
  assign out_sum = sum6_r;
  assign out_sb = {nay6_r, nax6_r, fl6_r, crd6_r};
endmodule

// ----- hw/rtl/tlso_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module tlso_sqrt #(
  parameter int SB_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [tlso_pkg::SQ_BITS-1:0] in_num,
  input  logic [SB_W-1:0] in_sb,
  output logic out_valid,
  output logic [tlso_pkg::ROOT_BITS-1:0] out_root,
  output logic [SB_W-1:0] out_sb
);
  localparam int N = tlso_pkg::ROOT_BITS;
  localparam int RW = N + 3;

  logic v_r [N];
  logic [RW-1:0] rem_r [N];
  logic [N-1:0] root_r [N];
  logic [2*N-1:0] num_r [N];
  logic [SB_W-1:0] sb_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic p_v;
    logic [RW-1:0] p_rem, rem2, trial;
    logic [N-1:0] p_root;
    logic [2*N-1:0] p_num;
    logic [SB_W-1:0] p_sb;
    if (k == 0) begin : g_first
      assign p_v = in_valid;
      assign p_rem = '0;
      assign p_root = '0;
      assign p_num = in_num;
      assign p_sb = in_sb;
    end else begin : g_next
      assign p_v = v_r[k-1];
      assign p_rem = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_num = num_r[k-1];
      assign p_sb = sb_r[k-1];
    end
    assign rem2 = {p_rem[RW-3:0], p_num[2*N-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem2 >= trial) begin
          rem_r[k] <= rem2 - trial;
          root_r[k] <= {p_root[N-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem2;
          root_r[k] <= {p_root[N-2:0], 1'b0};
        end
        num_r[k] <= p_num << 2;
        sb_r[k] <= p_sb;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root = root_r[N-1];
  assign out_sb = sb_r[N-1];
endmodule

// ----- hw/rtl/tlso_div.sv -----
// Pipelined two-lane restoring divider sharing one divisor.
module tlso_div #(
  parameter int SB_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [tlso_pkg::ROOT_BITS-1:0] in_len,
  input  logic [tlso_pkg::DIV_N_BITS-1:0] in_nx,
  input  logic [tlso_pkg::DIV_N_BITS-1:0] in_ny,
  input  logic [SB_W-1:0] in_sb,
  output logic out_valid,
  output logic [tlso_pkg::Q_BITS-1:0] out_qx,
  output logic [tlso_pkg::Q_BITS-1:0] out_qy,
  output logic [SB_W-1:0] out_sb
);
  localparam int N = tlso_pkg::Q_BITS;
  localparam int LW = tlso_pkg::ROOT_BITS;

  logic v_r [N];
  logic [LW-1:0] len_r [N];
  logic [SB_W-1:0] sb_r [N];
  logic [N-1:0] rem_r [2][N];
  logic [N-1:0] low_r [2][N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic p_v;
    logic [LW-1:0] p_len;
    logic [SB_W-1:0] p_sb;
    if (k == 0) begin : g_first
      assign p_v = in_valid;
      assign p_len = in_len;
      assign p_sb = in_sb;
    end else begin : g_next
      assign p_v = v_r[k-1];
      assign p_len = len_r[k-1];
      assign p_sb = sb_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k] <= p_len;
        sb_r[k] <= p_sb;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [N-1:0] p_rem, p_low;
      logic [N:0] t, diff;
      logic ge;
      if (k == 0) begin : g_first
        if (l == 0) begin : g_x
          assign p_rem = in_nx[2*N-1:N];
          assign p_low = in_nx[N-1:0];
        end else begin : g_y
          assign p_rem = in_ny[2*N-1:N];
          assign p_low = in_ny[N-1:0];
        end
      end else begin : g_next
        assign p_rem = rem_r[l][k-1];
        assign p_low = low_r[l][k-1];
      end
      assign t = {p_rem, p_low[N-1]};
      assign ge = t >= (N+1)'(p_len);
      assign diff = t - (N+1)'(p_len);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[l][k] <= ge ? diff[N-1:0] : t[N-1:0];
          low_r[l][k] <= {p_low[N-2:0], ge};
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_qx = low_r[0][N-1];
  assign out_qy = low_r[1][N-1];
  assign out_sb = sb_r[N-1];
endmodule

// ----- hw/rtl/thick_line_side_offset_core.sv -----
// Thick line side offset: perpendicular offset of a segment by the line width.
//
// Input stream in_*: one segment per request, tdata = {end_y, end_x, start_y,
// start_x}, signed fixed point, COORD_BITS each. Output stream out_*: tdata =
// {end_side_y, end_side_x, start_side_y, start_side_x}, saturated; tuser
// carries the degenerate flag (zero-length segment, zero offset).
// The thickness register sits at cfg address 0 (31 bits, unsigned fixed point)
// and is written over the APB-style port; the user must write it only while the
// core is idle; the block itself does not enforce this. The pipeline has 6 front
// stages, 31 square-root stages, 2 multiply/round stages, 31 divider stages, one
// offset/add stage and the output register. One request is taken per cycle while
// in_tready is high. The output has a two-entry skid; the pipeline advances
// unless the spare entry is full, so in_tready drops in the cycle after a second
// arrival with a result stalled. Nothing is dropped or repeated during a stall.
// Reset clears all valid bits and loads the thickness register with its default.
`include "thick_line_side_offset_core_macros.svh"
module thick_line_side_offset_core #(
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // start_side_x, start_side_y, end_side_x, end_side_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic [0:0] out_tuser,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int CB = COORD_BITS;
  localparam int NB = tlso_pkg::NORM_BITS;
  localparam int WB = tlso_pkg::W_BITS;
  localparam int RB = tlso_pkg::ROOT_BITS;
  localparam int QB = tlso_pkg::Q_BITS;
  localparam int DN = tlso_pkg::DIV_N_BITS;
  localparam int SBW = 4 * CB + 3;
  localparam int SQW = SBW + 2 * NB;
  localparam int SUMW = (CB > 32 ? CB : 32) + 2;
  localparam int DW = ((4 * CB + 7) / 8) * 8;

  logic [WB-1:0] width_r;
  logic en;
  logic cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel = cfg_paddr[2] == 1'(tlso_pkg::REG_THICKNESS);
  assign cfg_prdata = cfg_sel ? 32'(width_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= tlso_pkg::WIDTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel) begin
      width_r <= cfg_pwdata[WB-1:0];
    end
  end

  logic fr_v;
  logic [tlso_pkg::SQ_BITS-1:0] fr_sum;
  logic [SQW-1:0] fr_sb;

  tlso_front #(.COORD_BITS(CB)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid), .in_crd(in_tdata[4*CB-1:0]),
    .out_valid(fr_v), .out_sum(fr_sum), .out_sb(fr_sb)
  );

  logic sq_v;
  logic [RB-1:0] sq_root;
  logic [SQW-1:0] sq_sb;

  tlso_sqrt #(.SB_W(SQW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(fr_v), .in_num(fr_sum), .in_sb(fr_sb),
    .out_valid(sq_v), .out_root(sq_root), .out_sb(sq_sb)
  );

  logic m1_v_r, m2_v_r;
  logic [NB+WB-1:0] px1_r, py1_r;
  logic [RB-1:0] len1_r, len2_r;
  logic [SBW-1:0] sb1_r, sb2_r;
  logic [DN-1:0] nx2_r, ny2_r;
  logic [NB-1:0] sq_ax, sq_ay;

  assign sq_ax = sq_sb[SBW +: NB];
  assign sq_ay = sq_sb[SBW+NB +: NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= sq_v;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= sq_ax * width_r;
      py1_r <= sq_ay * width_r;
      len1_r <= sq_root;
      sb1_r <= sq_sb[SBW-1:0];
      nx2_r <= DN'(px1_r) + DN'(len1_r >> 1);
      ny2_r <= DN'(py1_r) + DN'(len1_r >> 1);
      len2_r <= len1_r;
      sb2_r <= sb1_r;
    end
  end

  logic dv_v;
  logic [QB-1:0] dv_qx, dv_qy;
  logic [SBW-1:0] dv_sb;

  tlso_div #(.SB_W(SBW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m2_v_r), .in_len(len2_r), .in_nx(nx2_r), .in_ny(ny2_r), .in_sb(sb2_r),
    .out_valid(dv_v), .out_qx(dv_qx), .out_qy(dv_qy), .out_sb(dv_sb)
  );

  logic dv_sdx, dv_sdy, dv_dg;
  logic signed [SUMW-1:0] offx, offy;
  logic o1_v_r, o1_dg_r;
  logic signed [SUMW-1:0] sum_r [4];

  assign dv_sdx = dv_sb[4*CB];
  assign dv_sdy = dv_sb[4*CB+1];
  assign dv_dg = dv_sb[4*CB+2];

  always_comb begin
    offx = '0;
    offy = '0;
    if (!dv_dg) begin
      offx = dv_sdy ? -$signed(SUMW'(dv_qy)) : $signed(SUMW'(dv_qy));
      offy = dv_sdx ? $signed(SUMW'(dv_qx)) : -$signed(SUMW'(dv_qx));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_v_r <= 1'b0;
    end else if (en) begin
      o1_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1_dg_r <= dv_dg;
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= SUMW'($signed(dv_sb[i*CB +: CB])) + ((i % 2 == 0) ? offx : offy);
      end
    end
  end

  logic [4*CB-1:0] sat;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!sum_r[i][SUMW-1] && (sum_r[i][SUMW-2:CB-1] != '0)) begin
        sat[i*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
      end else if (sum_r[i][SUMW-1] && (sum_r[i][SUMW-2:CB-1] != '1)) begin
        sat[i*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat[i*CB +: CB] = sum_r[i][CB-1:0];
      end
    end
  end

  logic out_v_r, sp_v_r, push;
  logic [4*CB:0] out_d_r, sp_d_r;

  assign en = !sp_v_r;
  assign in_tready = en;
  assign push = o1_v_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sp_v_r <= 1'b0;
    end else if (sp_v_r) begin
      if (out_tready) sp_v_r <= 1'b0;
    end else if (push) begin
      if (out_v_r && !out_tready) sp_v_r <= 1'b1;
      else out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sp_v_r) begin
      if (out_tready) out_d_r <= sp_d_r;
    end else if (push) begin
      if (out_v_r && !out_tready) sp_d_r <= {o1_dg_r, sat};
      else out_d_r <= {o1_dg_r, sat};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = DW'(out_d_r[4*CB-1:0]);
  assign out_tuser = out_d_r[4*CB];

  `TLSO_ASSERT_IMPL(a_spare_needs_out, sp_v_r, out_v_r)
  `TLSO_ASSERT_NEXT(a_spare_held, sp_v_r && !out_tready, sp_v_r && out_v_r)
  `TLSO_ASSERT_NEXT(a_out_kept, out_v_r && !out_tready, out_v_r)
endmodule

// ----- test/tb_top.sv -----
// Testbench for thick_line_side_offset_core: random and directed segments checked against a predictor.
class side_offset_board;
  typedef struct packed {
    logic [31:0] sy1;
    logic [31:0] sx1;
    logic [31:0] sy0;
    logic [31:0] sx0;
    logic        degen;
  } quad_edge_t;
  quad_edge_t pending_edges[$];
  logic [30:0] width;
  int errors;
  int checked;
  int degen_seen;

  function new();
    width = tlso_pkg::WIDTH_RESET;
    errors = 0;
    checked = 0;
    degen_seen = 0;
  endfunction

  static function logic [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function void note_segment(logic [127:0] d);
    quad_edge_t e;
    longint x0, y0, x1, y1, dx, dy, offx, offy;
    longint unsigned ax, ay, mx, len, qx, qy;
    x0 = $signed(d[31:0]);
    y0 = $signed(d[63:32]);
    x1 = $signed(d[95:64]);
    y1 = $signed(d[127:96]);
    dx = x1 - x0;
    dy = y1 - y0;
    offx = 0;
    offy = 0;
    e.degen = (dx == 0 && dy == 0);
    if (!e.degen) begin
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      mx = ax > ay ? ax : ay;
      while (mx >= (64'd1 << 30)) begin
        ax >>= 1; ay >>= 1; mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        ax <<= 1; ay <<= 1; mx <<= 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      qy = (ay * width + (len >> 1)) / len;
      qx = (ax * width + (len >> 1)) / len;
      offx = dy < 0 ? -longint'(qy) : longint'(qy);
      offy = dx < 0 ? longint'(qx) : -longint'(qx);
    end
    e.sx0 = clamp(x0 + offx);
    e.sy0 = clamp(y0 + offy);
    e.sx1 = clamp(x1 + offx);
    e.sy1 = clamp(y1 + offy);
    pending_edges.push_back(e);
  endfunction

  function void check_edge(logic [127:0] d, logic dg);
    quad_edge_t e;
    if (pending_edges.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    e = pending_edges.pop_front();
    checked++;
    if (dg) degen_seen++;
    if (d[31:0] !== e.sx0) begin
      $error("start_side_x exp %h got %h", e.sx0, d[31:0]); errors++;
    end
    if (d[63:32] !== e.sy0) begin
      $error("start_side_y exp %h got %h", e.sy0, d[63:32]); errors++;
    end
    if (d[95:64] !== e.sx1) begin
      $error("end_side_x exp %h got %h", e.sx1, d[95:64]); errors++;
    end
    if (d[127:96] !== e.sy1) begin
      $error("end_side_y exp %h got %h", e.sy1, d[127:96]); errors++;
    end
    if (dg !== e.degen) begin
      $error("degenerate exp %0d got %0d", e.degen, dg); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int LATENCY = 72;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [127:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 0;
  logic cfg_penable = 0;
  logic cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int sent = 0;
  longint cycles = 0;
  side_offset_board board;

  thick_line_side_offset_core uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_edge(out_tdata, out_tuser[0]);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_width(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 3'(tlso_pkg::REG_THICKNESS * 4); cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    board.width = v[30:0];
  endtask

  task automatic send_segment(logic [31:0] x0, y0, x1, y1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {y1, x1, y0, x0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_segment(in_tdata);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending_edges.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fffffff - $urandom_range(3);
      2: return 32'h80000000 + $urandom_range(3);
      3: return $urandom_range(32'h3ffff) - 32'h1ffff;
      default: return $urandom_range(32'h7ffffff) - 32'h3ffffff;
    endcase
  endfunction

  task automatic random_segments(int n);
    logic [31:0] x0, y0, x1, y1;
    repeat (n) begin
      x0 = rand_coord();
      y0 = rand_coord();
      case ($urandom_range(9))
        0: begin x1 = x0; y1 = y0; end
        1: begin x1 = rand_coord(); y1 = y0; end
        2: begin x1 = x0; y1 = rand_coord(); end
        3: begin x1 = x0 + $urandom_range(7) - 3; y1 = y0 + $urandom_range(7) - 3; end
        default: begin x1 = rand_coord(); y1 = rand_coord(); end
      endcase
      send_segment(x0, y0, x1, y1);
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: axis cases, zero length, extremes, saturation
    send_segment(0, 0, 32'h10000, 0);
    send_segment(0, 0, -32'sh10000, 0);
    send_segment(0, 0, 0, 32'h10000);
    send_segment(0, 0, 0, -32'sh10000);
    send_segment(32'h1234, 32'h5678, 32'h1234, 32'h5678);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_segment(32'h7fffffff, 0, 32'h80000000, 0);
    send_segment(0, 32'h80000000, 0, 32'h7fffffff);
    send_segment(0, 0, 1, 1);
    send_segment(0, 0, 3, -32'sd4);
    send_segment(32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00050000);
    drain();
    write_width(32'hffffffff);
    send_segment(0, 0, 32'h10000, 0);
    send_segment(0, 0, 0, 32'h10000);
    send_segment(32'h7fff0000, 32'h7fff0000, 32'h80000000, 32'h80000000);
    send_segment(5, 5, 7, 9);
    drain();
    write_width(0);
    send_segment(0, 0, 32'h10000, 32'h30000);
    send_segment(32'h80000000, 0, 32'h7fffffff, 0);
    drain();
    write_width(32'h00018000);

    send_idle_pct = 30; recv_idle_pct = 61;
    random_segments(300);
    drain();
    write_width($urandom & 32'h003fffff);
    send_idle_pct = 61; recv_idle_pct = 30;
    random_segments(300);
    hold_off = 400;
    send_idle_pct = 0;
    random_segments(150);
    drain();
    write_width($urandom);
    recv_idle_pct = 0;
    random_segments(180);
    drain();

    $display("%0d segments sent, %0d results checked (%0d zero-length), 6 thickness settings",
             sent, board.checked, board.degen_seen);
    if (board.errors == 0 && board.pending_edges.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tlso_pkg.sv
hw/rtl/tlso_front.sv
hw/rtl/tlso_sqrt.sv
hw/rtl/tlso_div.sv
hw/rtl/thick_line_side_offset_core.sv
test/tb_top.sv
